>>> rtl/snc_pkg.sv
// shared constants, types and gradient table for the simplex noise pipeline
package snc_pkg;

  // corners per simplex and pipeline depth of each section
  localparam int NUM_CORNERS = 4;
  localparam int CELL_LAT    = 4;
  localparam int CORNER_LAT  = 7;
  localparam int SUM_LAT     = 4;

  // hash primes, one per axis
  localparam logic [31:0] PRIME_X = 32'd73856093;
  localparam logic [31:0] PRIME_Y = 32'd19349663;
  localparam logic [31:0] PRIME_Z = 32'd83492791;

  // single-precision field layout
  localparam int MANT_BITS  = 23;
  localparam int FLOAT_BIAS = 127;

  typedef logic signed [1:0] gcomp_t;

  typedef struct packed {
    gcomp_t gx;
    gcomp_t gy;
    gcomp_t gz;
  } grad_t;

  // gradient directions, edge midpoints of a cube
  function automatic grad_t grad_lookup(input logic [3:0] idx);
    grad_t g;
    g = '0;
    unique case (idx)
      4'd0:    g = '{2'sd1,  2'sd1,  2'sd0};
      4'd1:    g = '{-2'sd1, 2'sd1,  2'sd0};
      4'd2:    g = '{2'sd1,  -2'sd1, 2'sd0};
      4'd3:    g = '{-2'sd1, -2'sd1, 2'sd0};
      4'd4:    g = '{2'sd1,  2'sd0,  2'sd1};
      4'd5:    g = '{-2'sd1, 2'sd0,  2'sd1};
      4'd6:    g = '{2'sd1,  2'sd0,  -2'sd1};
      4'd7:    g = '{-2'sd1, 2'sd0,  -2'sd1};
      4'd8:    g = '{2'sd0,  2'sd1,  2'sd1};
      4'd9:    g = '{2'sd0,  -2'sd1, 2'sd1};
      4'd10:   g = '{2'sd0,  2'sd1,  -2'sd1};
      4'd11:   g = '{2'sd0,  -2'sd1, -2'sd1};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

>>> rtl/snc_cell.sv
// skew, cell floor, unskew and corner selection, four register stages
module snc_cell #(
  parameter int COORD_FRAC_BITS = 16,
  localparam int CW = 35 - COORD_FRAC_BITS,
  localparam int DW = COORD_FRAC_BITS + 5
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  input  logic signed [31:0] z_coord,
  output logic out_valid,
  output logic [snc_pkg::NUM_CORNERS-1:0][2:0][CW-1:0] corner_pos,
  output logic [snc_pkg::NUM_CORNERS-1:0][2:0][DW-1:0] corner_off
);
  import snc_pkg::*;

  localparam int F   = COORD_FRAC_BITS;
  localparam int AW  = 36 - F;
  localparam int UW  = AW + 1;
  localparam int K3  = UW + 2;
  localparam int QPW = K3 + UW;
  localparam logic [K3-2:0] M3 = (K3-1)'(((64'd1 << K3) + 64'd2) / 64'd3);
  localparam longint U_OFFS = 3 * (longint'(1) << (AW - 2));
  localparam longint I_OFFS = longint'(1) << (AW - 2);
  localparam logic [DW-1:0] D_ONE   = DW'(64'd1 << F);
  localparam logic [DW-1:0] D_TWO   = DW'(64'd2 << F);
  localparam logic [DW-1:0] D_THREE = DW'(64'd3 << F);
  localparam logic [DW-1:0] D_SIX   = DW'(64'd6 << F);

  logic [CELL_LAT-1:0] vld_r;

  logic signed [31:0] coord [3];
  logic signed [35:0] s36;
  logic signed [35:0] nsk [3];
  logic signed [AW-1:0] ask [3];
  logic signed [UW:0] usum [3];
  logic [UW-1:0] u_nxt [3];
  logic [UW-1:0] u_r [3];
  logic signed [31:0] coord1_r [3];

  logic [QPW-1:0] prod [3];
  logic [UW-1:0] q3 [3];
  logic [UW-1:0] idiff [3];
  logic signed [CW-1:0] i0_nxt [3];
  logic signed [CW-1:0] i0_r [3];
  logic signed [31:0] coord2_r [3];

  logic [DW-1:0] c_lo [3];
  logic [DW-1:0] ip [3];
  logic [DW-1:0] isum;
  logic signed [DW-1:0] x0_nxt [3];
  logic signed [DW-1:0] x0_r [3];
  logic signed [CW-1:0] i0_3r [3];

  logic [2:0] fl1;
  logic [2:0] fl2;
  logic [NUM_CORNERS-1:0][2:0][CW-1:0] pos_nxt;
  logic [NUM_CORNERS-1:0][2:0][DW-1:0] off_nxt;
  logic [NUM_CORNERS-1:0][2:0][CW-1:0] pos_r;
  logic [NUM_CORNERS-1:0][2:0][DW-1:0] off_r;

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[CELL_LAT-2:0], in_valid};
    end
  end

  // stage 1: skewed sums, scaled to whole cells, offset to non-negative
  always_comb begin
    coord[0] = x_coord;
    coord[1] = y_coord;
    coord[2] = z_coord;
    s36 = 36'(x_coord) + 36'(y_coord) + 36'(z_coord);
    for (int k = 0; k < 3; k++) begin
      nsk[k]   = (36'(coord[k]) <<< 1) + 36'(coord[k]) + s36;
      ask[k]   = AW'(nsk[k] >>> F);
      usum[k]  = (UW+1)'(ask[k]) + (UW+1)'(U_OFFS);
      u_nxt[k] = usum[k][UW-1:0];
    end
  end

  // stage 2: divide by three through the reciprocal, remove offset
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k]   = QPW'(u_r[k]) * QPW'(M3);
      q3[k]     = prod[k][K3 +: UW];
      idiff[k]  = q3[k] - UW'(I_OFFS);
      i0_nxt[k] = idiff[k][CW-1:0];
    end
  end

  // stage 3: unskewed offsets of the first corner, modulo the offset width
  always_comb begin
    isum = DW'(i0_r[0]) + DW'(i0_r[1]) + DW'(i0_r[2]);
    for (int k = 0; k < 3; k++) begin
      c_lo[k]   = coord2_r[k][DW-1:0];
      ip[k]     = DW'(i0_r[k]) << F;
      x0_nxt[k] = (c_lo[k] << 2) + (c_lo[k] << 1) - ((ip[k] << 2) + (ip[k] << 1))
                + (isum << F);
    end
  end

  // stage 4: order the offsets and build all four corners
  always_comb begin
    fl1[0] = (x0_r[0] >= x0_r[1]) && (x0_r[0] >= x0_r[2]);
    fl1[1] = (x0_r[1] >  x0_r[0]) && (x0_r[1] >= x0_r[2]);
    fl1[2] = (x0_r[2] >  x0_r[0]) && (x0_r[2] >  x0_r[1]);
    fl2[0] = (x0_r[0] >= x0_r[1]) || (x0_r[0] >= x0_r[2]);
    fl2[1] = (x0_r[1] >  x0_r[0]) || (x0_r[1] >= x0_r[2]);
    fl2[2] = (x0_r[2] >  x0_r[0]) || (x0_r[2] >  x0_r[1]);
    for (int k = 0; k < 3; k++) begin
      pos_nxt[0][k] = i0_3r[k];
      pos_nxt[1][k] = i0_3r[k] + CW'(fl1[k]);
      pos_nxt[2][k] = i0_3r[k] + CW'(fl2[k]);
      pos_nxt[3][k] = i0_3r[k] + CW'(1);
      off_nxt[0][k] = x0_r[k];
      off_nxt[1][k] = x0_r[k] - (fl1[k] ? D_SIX : '0) + D_ONE;
      off_nxt[2][k] = x0_r[k] - (fl2[k] ? D_SIX : '0) + D_TWO;
      off_nxt[3][k] = x0_r[k] - D_THREE;
    end
  end

  // data registers of all four stages
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      u_r[k]      <= u_nxt[k];
      coord1_r[k] <= coord[k];
      i0_r[k]     <= i0_nxt[k];
      coord2_r[k] <= coord1_r[k];
      x0_r[k]     <= x0_nxt[k];
      i0_3r[k]    <= i0_r[k];
    end
    pos_r <= pos_nxt;
    off_r <= off_nxt;
  end

  assign out_valid  = vld_r[CELL_LAT-1];
  assign corner_pos = pos_r;
  assign corner_off = off_r;

  // exactly one axis steps for the second corner, two for the third
  a_second_corner: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> $onehot(fl1))
    else $error("second corner must step along exactly one axis");

  a_third_corner: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> ($countones(fl2) == 2))
    else $error("third corner must step along exactly two axes");

endmodule

>>> rtl/snc_corner.sv
// one simplex corner: falloff, float-pattern hash, gradient dot, contribution
module snc_corner #(
  parameter int COORD_FRAC_BITS = 16,
  localparam int CW = 35 - COORD_FRAC_BITS,
  localparam int DW = COORD_FRAC_BITS + 5,
  localparam int PW = COORD_FRAC_BITS + 40
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic [2:0][CW-1:0] corner_pos,
  input  logic [2:0][DW-1:0] corner_off,
  input  logic [31:0] noise_seed,
  output logic out_valid,
  output logic signed [PW-1:0] contrib
);
  import snc_pkg::*;

  localparam int F   = COORD_FRAC_BITS;
  localparam int EW  = $clog2(CW);
  localparam int SQW = 2 * DW;
  localparam int TW  = SQW + 3;
  localparam int VW  = 35;
  localparam int E   = 2 * F - 30;
  localparam int ER  = (E >= 0) ? E : 0;
  localparam int EL  = (E < 0) ? -E : 0;
  localparam longint T_MAX = longint'(18) << (2 * F);
  localparam logic [35:0] M9 = 36'(((64'd1 << 39) + 64'd8) / 64'd9);
  localparam logic [31:0] PRIMES [3] = '{PRIME_X, PRIME_Y, PRIME_Z};

  logic [CORNER_LAT-1:0] vld_r;

  // stage 1 signals
  logic signed [CW-1:0] cpos [3];
  logic signed [DW-1:0] doff [3];
  logic signed [SQW-1:0] dd [3];
  logic [CW-1:0] mag [3];
  logic [EW-1:0] lead [3];
  logic [SQW-1:0] sq_r [3];
  logic [CW-1:0] mag_r [3];
  logic [EW-1:0] lead_r [3];
  logic [2:0] sgn_r;
  logic [2:0] zero_r;
  logic signed [DW-1:0] d1_r [3];

  // stage 2 signals
  logic [SQW+1:0] r2;
  logic signed [TW-1:0] tval;
  logic [VW-1:0] v_nxt;
  logic [23:0] mant [3];
  logic [31:0] fbits [3];
  logic pos2_r;
  logic [VW-1:0] v_r;
  logic [31:0] fb_r [3];
  logic signed [DW-1:0] d2_r [3];

  // stage 3 signals
  logic pos3_r;
  logic [53:0] ph_r;
  logic [52:0] pl_r;
  logic [31:0] hp_r [3];
  logic signed [DW-1:0] d3_r [3];

  // stage 4 signals
  logic [71:0] tqw;
  logic [31:0] hsh;
  logic [35:0] h12;
  grad_t grad;
  gcomp_t gc [3];
  logic signed [DW+1:0] term [3];
  logic signed [DW+1:0] dot_nxt;
  logic pos4_r;
  logic [31:0] tq_r;
  logic signed [DW+1:0] dot4_r;

  // stages 5 to 7
  logic [63:0] tsq;
  logic [63:0] t2sq;
  logic pos5_r;
  logic pos6_r;
  logic [31:0] t2_r;
  logic [31:0] t4_r;
  logic signed [DW+1:0] dot5_r;
  logic signed [DW+1:0] dot6_r;
  logic signed [PW-1:0] contrib_r;

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[CORNER_LAT-2:0], in_valid};
    end
  end

  // stage 1: squared offsets, magnitude and leading one of each coordinate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cpos[k] = $signed(corner_pos[k]);
      doff[k] = $signed(corner_off[k]);
      dd[k]   = SQW'(doff[k]) * SQW'(doff[k]);
      mag[k]  = cpos[k][CW-1] ? CW'(-cpos[k]) : corner_pos[k];
      lead[k] = '0;
      for (int b = 0; b < CW; b++) begin
        if (mag[k][b]) begin
          lead[k] = EW'(b);
        end
      end
    end
  end

  // stage 2: falloff before scaling, float bit patterns
  always_comb begin
    r2    = (SQW+2)'(sq_r[0]) + (SQW+2)'(sq_r[1]) + (SQW+2)'(sq_r[2]);
    tval  = TW'(T_MAX) - TW'(r2);
    v_nxt = VW'(((TW+EL)'(tval) <<< EL) >>> ER);
    for (int k = 0; k < 3; k++) begin
      if (int'(lead_r[k]) > MANT_BITS) begin
        mant[k] = 24'(mag_r[k] >> (int'(lead_r[k]) - MANT_BITS));
      end else begin
        mant[k] = 24'({24'b0, mag_r[k]} << (MANT_BITS - int'(lead_r[k])));
      end
      fbits[k] = zero_r[k] ? '0
               : {sgn_r[k], 8'(int'(lead_r[k]) + FLOAT_BIAS), mant[k][MANT_BITS-1:0]};
    end
  end

  // stage 4: finish divide by 36, hash to gradient, dot product
  always_comb begin
    tqw  = 72'({ph_r, 17'b0}) + 72'(pl_r);
    hsh  = hp_r[0] ^ hp_r[1] ^ hp_r[2] ^ noise_seed;
    h12  = 36'({hsh, 3'b0}) + 36'({hsh, 2'b0});
    grad = grad_lookup(h12[35:32]);
    gc[0] = grad.gx;
    gc[1] = grad.gy;
    gc[2] = grad.gz;
    for (int k = 0; k < 3; k++) begin
      unique case (gc[k])
        2'sd1:   term[k] = (DW+2)'(d3_r[k]);
        -2'sd1:  term[k] = -(DW+2)'(d3_r[k]);
        default: term[k] = '0;
      endcase
    end
    dot_nxt = term[0] + term[1] + term[2];
  end

  // stages 5 and 6: square of the falloff, twice
  always_comb begin
    tsq  = 64'(tq_r) * 64'(tq_r);
    t2sq = 64'(t2_r) * 64'(t2_r);
  end

  // data registers of all stages
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq_r[k]   <= dd[k];
      mag_r[k]  <= mag[k];
      lead_r[k] <= lead[k];
      sgn_r[k]  <= cpos[k][CW-1];
      zero_r[k] <= (mag[k] == '0);
      d1_r[k]   <= doff[k];
      fb_r[k]   <= fbits[k];
      d2_r[k]   <= d1_r[k];
      hp_r[k]   <= fb_r[k] * PRIMES[k];
      d3_r[k]   <= d2_r[k];
    end
    pos2_r    <= (tval > 0);
    v_r       <= v_nxt;
    pos3_r    <= pos2_r;
    ph_r      <= 54'(v_r[VW-1:17]) * 54'(M9);
    pl_r      <= 53'(v_r[16:0]) * 53'(M9);
    pos4_r    <= pos3_r;
    tq_r      <= tqw[39 +: 32];
    dot4_r    <= dot_nxt;
    pos5_r    <= pos4_r;
    t2_r      <= tsq[63:32];
    dot5_r    <= dot4_r;
    pos6_r    <= pos5_r;
    t4_r      <= t2sq[63:32];
    dot6_r    <= dot5_r;
    contrib_r <= pos6_r ? $signed(PW'({1'b0, t4_r})) * PW'(dot6_r) : '0;
  end

  assign out_valid = vld_r[CORNER_LAT-1];
  assign contrib   = contrib_r;

  // a live corner's falloff never exceeds one half
  a_falloff_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[3] && pos4_r) |-> (tq_r <= 32'h8000_0000))
    else $error("scaled falloff out of range");

endmodule

>>> rtl/snc_sum.sv
// corner sum, scale by 76, floor to output format and saturate
module snc_sum #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS = 30,
  localparam int PW = COORD_FRAC_BITS + 40
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic [snc_pkg::NUM_CORNERS-1:0][PW-1:0] contrib,
  output logic out_valid,
  output logic signed [31:0] noise_value
);
  import snc_pkg::*;

  localparam int SW  = PW + 2;
  localparam int VW  = SW + 6;
  localparam int SH  = 32 + COORD_FRAC_BITS - OUT_FRAC_BITS;
  localparam longint W_MAX  = 64'sd6442450943;
  localparam longint W_MIN  = -64'sd6442450944;
  localparam longint W_OFFS = 64'sd6442450944;
  localparam logic [34:0] M3 = 35'(((64'd1 << 36) + 64'd2) / 64'd3);

  logic [SUM_LAT-1:0] vld_r;
  logic signed [SW-1:0] sum_nxt;
  logic signed [SW-1:0] sum_r;
  logic signed [VW-1:0] vsc;
  logic signed [VW-1:0] wsh;
  logic signed [VW-1:0] wcl;
  logic [VW-1:0] usum;
  logic [33:0] u_r;
  logic [51:0] ph_r;
  logic [51:0] pl_r;
  logic [69:0] qw;
  logic [31:0] out_r;

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SUM_LAT-2:0], in_valid};
    end
  end

  // stage 1: exact sum of the corners
  always_comb begin
    sum_nxt = '0;
    for (int c = 0; c < NUM_CORNERS; c++) begin
      sum_nxt = sum_nxt + SW'($signed(contrib[c]));
    end
  end

  // stage 2: times 38, drop fraction, clamp so that a third stays in range
  always_comb begin
    vsc = (VW'(sum_r) <<< 5) + (VW'(sum_r) <<< 2) + (VW'(sum_r) <<< 1);
    wsh = vsc >>> SH;
    if (wsh > VW'(W_MAX)) begin
      wcl = VW'(W_MAX);
    end else if (wsh < VW'(W_MIN)) begin
      wcl = VW'(W_MIN);
    end else begin
      wcl = wsh;
    end
    usum = wcl + VW'(W_OFFS);
  end

  // stage 4: finish the divide by three, remove offset
  assign qw = 70'({ph_r, 17'b0}) + 70'(pl_r);

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    u_r   <= usum[33:0];
    ph_r  <= 52'(u_r[33:17]) * 52'(M3);
    pl_r  <= 52'(u_r[16:0]) * 52'(M3);
    out_r <= {~qw[67], qw[66:36]};
  end

  assign out_valid   = vld_r[SUM_LAT-1];
  assign noise_value = $signed(out_r);

endmodule

>>> rtl/simplex_noise_3d_top.sv
// 3d simplex noise: one point in, one saturated noise value out, fully pipelined
//
// Takes one point per clock, with no gaps: busy stays low, so every cycle with
// start high is a new request. The result appears on out_noise_value with
// out_valid high for one cycle, after cell and corner setup, the per-corner
// pipelines that run the four corners side by side, and summing and final
// division, in request order. The receiver cannot stall and must take each
// result when it is shown. The seed is written through cfg_valid/cfg_ready,
// which is always ready; write it only while no request is in flight.
module simplex_noise_3d_top #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS = 30
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic signed [31:0] in_x_coord,
  input  logic signed [31:0] in_y_coord,
  input  logic signed [31:0] in_z_coord,
  output logic out_valid,
  output logic signed [31:0] out_noise_value,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [31:0] cfg_noise_seed
);
  import snc_pkg::*;

  localparam int CW = 35 - COORD_FRAC_BITS;
  localparam int DW = COORD_FRAC_BITS + 5;
  localparam int PW = COORD_FRAC_BITS + 40;
  localparam int LATENCY = CELL_LAT + CORNER_LAT + SUM_LAT;

  logic [31:0] noise_seed_r;
  logic cell_valid;
  logic [NUM_CORNERS-1:0][2:0][CW-1:0] corner_pos;
  logic [NUM_CORNERS-1:0][2:0][DW-1:0] corner_off;
  logic [NUM_CORNERS-1:0] corner_valid;
  logic [NUM_CORNERS-1:0][PW-1:0] contrib;

  // always able to take a request
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_seed_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      noise_seed_r <= cfg_noise_seed;
    end
  end

  // lattice cell and corner offsets
  snc_cell #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_cell (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start && !busy),
    .x_coord    (in_x_coord),
    .y_coord    (in_y_coord),
    .z_coord    (in_z_coord),
    .out_valid  (cell_valid),
    .corner_pos (corner_pos),
    .corner_off (corner_off)
  );

  // four corner lanes in parallel
  for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_corner
    snc_corner #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_corner (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_valid   (cell_valid),
      .corner_pos (corner_pos[c]),
      .corner_off (corner_off[c]),
      .noise_seed (noise_seed_r),
      .out_valid  (corner_valid[c]),
      .contrib    (contrib[c])
    );
  end

  // sum, scale and saturate
  snc_sum #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_sum (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (corner_valid[0]),
    .contrib     (contrib),
    .out_valid   (out_valid),
    .noise_value (out_noise_value)
  );

  // every request yields a result after the fixed latency
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("request produced no result");

  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without a request");

  // corner lanes stay in lockstep
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (corner_valid == '0) || (corner_valid == '1))
    else $error("corner lanes out of step");

endmodule
